>>> design/ggpf_pkg.sv
`default_nettype none
package ggpf_pkg;

  localparam int GRID_SIDE_BITS_DEF = 8;
  localparam int COORD_BITS_DEF     = 20;
  localparam int COUNT_BITS_DEF     = 16;

  localparam int RANGE_W   = 40;
  localparam int RECIP_W   = 25;
  localparam int MARGIN_W  = 16;
  localparam int STEPS_W   = 4;
  localparam int MINPTS_W  = 16;
  localparam int PASS_BITS = 4;
  localparam int CFG_IDX_W = 3;
  localparam int RECIP_FRAC = 24;

  localparam logic [RANGE_W-1:0]  RANGE_RST  = 40'd1600000000;
  localparam logic [RECIP_W-1:0]  RECIP_RST  = 25'd33554;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd250;
  localparam logic [STEPS_W-1:0]  STEPS_RST  = 4'd3;
  localparam logic [MINPTS_W-1:0] MINPTS_RST = 16'd1;

  typedef enum logic [1:0] {
    REQ_CLEAR    = 2'd0,
    REQ_ACCUM    = 2'd1,
    REQ_FINISH   = 2'd2,
    REQ_CLASSIFY = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    VERD_GROUND = 3'd0,
    VERD_ABOVE  = 3'd1,
    VERD_RANGE  = 3'd2,
    VERD_NOCELL = 3'd3,
    VERD_ACK    = 3'd4
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_RANGE_SQ   = 3'd0,
    CFG_CELL_RECIP     = 3'd1,
    CFG_HEIGHT_MARGIN  = 3'd2,
    CFG_DILATION_STEPS = 3'd3,
    CFG_MIN_POINTS     = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_PT_RD,
    ST_PT_UPD,
    ST_CLR,
    ST_THIN_RD,
    ST_THIN_WR,
    ST_DIL_RD,
    ST_DIL_CHK,
    ST_DIL_NRD,
    ST_DIL_NCHK,
    ST_DIL_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic range_ok;
    logic on_grid;
  } pt_flags_t;

endpackage
`default_nettype wire

>>> design/grid_ground_point_filter.sv
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata: x_mm, y_mm, z_mm; tuser: req_type
// m_axis    out        tdata: keep_point, verdict
// cfg       in         index and write data of one register
// Accumulate and classify pass through the point calculation and one grid-memory
// access and then hand the result over; accumulate reads a cell and writes it back
// when the point is in range and on the grid, classify only reads it. Clear writes
// every cell in turn; finish sweeps every cell to drop thin cells and sweeps again
// for each fill pass, bound by the single read port of the grid memory.
// After reset the grid is swept once, one cell per cycle, before the first word
// is taken. A stalled output holds only the result; the next word is still
// taken and worked on.
module grid_ground_point_filter #(
  parameter int GRID_SIDE_BITS = ggpf_pkg::GRID_SIDE_BITS_DEF,
  parameter int COORD_BITS     = ggpf_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS     = ggpf_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // x_mm, y_mm, z_mm from bit 0 up, zero padded
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  wire logic [1:0]                      s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // keep_point, verdict from bit 0 up, zero padded
  output logic [7:0]                           m_axis_tdata_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ggpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ggpf_pkg::RANGE_W-1:0]    cfg_data_i
);

  localparam int AW = 2 * GRID_SIDE_BITS;
  localparam int PB = ggpf_pkg::PASS_BITS;
  localparam int DW = 1 + PB + COORD_BITS + COUNT_BITS;
  localparam int H_LSB = COUNT_BITS;
  localparam int P_LSB = COUNT_BITS + COORD_BITS;
  localparam int V_BIT = DW - 1;
  localparam int HW = ((COORD_BITS > ggpf_pkg::MARGIN_W) ? COORD_BITS
                      : ggpf_pkg::MARGIN_W) + 2;
  localparam int CW = (COUNT_BITS > ggpf_pkg::MINPTS_W) ? COUNT_BITS
                      : ggpf_pkg::MINPTS_W;

  logic [ggpf_pkg::RANGE_W-1:0]  max_range_q;
  logic [ggpf_pkg::RECIP_W-1:0]  recip_q;
  logic [ggpf_pkg::MARGIN_W-1:0] margin_q;
  logic [ggpf_pkg::STEPS_W-1:0]  steps_q;
  logic [ggpf_pkg::MINPTS_W-1:0] minpts_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_range_q <= ggpf_pkg::RANGE_RST;
      recip_q     <= ggpf_pkg::RECIP_RST;
      margin_q    <= ggpf_pkg::MARGIN_RST;
      steps_q     <= ggpf_pkg::STEPS_RST;
      minpts_q    <= ggpf_pkg::MINPTS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ggpf_pkg::CFG_MAX_RANGE_SQ:   max_range_q <= cfg_data_i;
        ggpf_pkg::CFG_CELL_RECIP:     recip_q <= cfg_data_i[ggpf_pkg::RECIP_W-1:0];
        ggpf_pkg::CFG_HEIGHT_MARGIN:  margin_q <= cfg_data_i[ggpf_pkg::MARGIN_W-1:0];
        ggpf_pkg::CFG_DILATION_STEPS: steps_q <= cfg_data_i[ggpf_pkg::STEPS_W-1:0];
        ggpf_pkg::CFG_MIN_POINTS:     minpts_q <= cfg_data_i[ggpf_pkg::MINPTS_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured word.
  ggpf_pkg::req_e          req_q;
  logic signed [COORD_BITS-1:0] x_q, y_q, z_q;

  ggpf_pkg::pt_flags_t flags;
  logic [AW-1:0]       pt_addr;

  ggpf_point_calc #(
    .GRID_SIDE_BITS(GRID_SIDE_BITS),
    .COORD_BITS(COORD_BITS)
  ) u_calc (
    .clk_i(clk_i),
    .x_i(x_q),
    .y_i(y_q),
    .z_i(z_q),
    .max_range_sq_i(max_range_q),
    .cell_recip_i(recip_q),
    .flags_o(flags),
    .addr_o(pt_addr)
  );

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  ggpf_grid_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk_i(clk_i),
    .we_i(we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  ggpf_pkg::state_e state_q, state_d;
  logic [AW-1:0]    cell_q, cell_d;
  logic [PB-1:0]    pass_q, pass_d;
  logic [1:0]       dir_q, dir_d;
  logic             found_q, found_d;
  logic signed [COORD_BITS-1:0] best_q, best_d;
  logic             res_keep_q, res_keep_d;
  ggpf_pkg::verdict_e res_verd_q, res_verd_d;
  logic             out_valid_q, out_valid_d;
  logic             out_keep_q, out_keep_d;
  ggpf_pkg::verdict_e out_verd_q, out_verd_d;
  logic             accept;

  logic r_valid;
  logic [PB-1:0] r_pass;
  logic signed [COORD_BITS-1:0] r_h;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [GRID_SIDE_BITS-1:0] cx, cy;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic signed [HW-1:0] lim_h;
  logic last_cell;

  assign r_valid = rdata[V_BIT];
  assign r_pass  = rdata[P_LSB +: PB];
  assign r_h     = $signed(rdata[H_LSB +: COORD_BITS]);
  assign r_cnt   = rdata[COUNT_BITS-1:0];
  assign cx = cell_q[GRID_SIDE_BITS-1:0];
  assign cy = cell_q[AW-1:GRID_SIDE_BITS];
  assign last_cell = &cell_q;
  assign lim_h = HW'(r_h) + $signed(HW'(margin_q));
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ggpf_pkg::ST_IDLE);

  always_comb begin
    unique case (dir_q)
      2'd0: begin
        nb_ok = (cx != '0);
        nb_addr = {cy, cx - 1'b1};
      end
      2'd1: begin
        nb_ok = (cx != '1);
        nb_addr = {cy, cx + 1'b1};
      end
      2'd2: begin
        nb_ok = (cy != '0);
        nb_addr = {cy - 1'b1, cx};
      end
      default: begin
        nb_ok = (cy != '1);
        nb_addr = {cy + 1'b1, cx};
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    cell_d = cell_q;
    pass_d = pass_q;
    dir_d = dir_q;
    found_d = found_q;
    best_d = best_q;
    res_keep_d = res_keep_q;
    res_verd_d = res_verd_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_keep_d = out_keep_q;
    out_verd_d = out_verd_q;
    we = 1'b0;
    waddr = cell_q;
    wdata = '0;
    raddr = cell_q;
    unique case (state_q)
      ggpf_pkg::ST_INIT, ggpf_pkg::ST_CLR: begin
        we = 1'b1;
        cell_d = cell_q + 1'b1;
        if (last_cell) begin
          state_d = (state_q == ggpf_pkg::ST_INIT) ? ggpf_pkg::ST_IDLE
                                                   : ggpf_pkg::ST_DONE;
        end
      end
      ggpf_pkg::ST_IDLE: begin
        res_keep_d = 1'b0;
        res_verd_d = ggpf_pkg::VERD_ACK;
        cell_d = '0;
        if (accept) begin
          unique case (ggpf_pkg::req_e'(s_axis_tuser_i))
            ggpf_pkg::REQ_CLEAR:  state_d = ggpf_pkg::ST_CLR;
            ggpf_pkg::REQ_FINISH: state_d = ggpf_pkg::ST_THIN_RD;
            default:              state_d = ggpf_pkg::ST_CALC1;
          endcase
        end
      end
      ggpf_pkg::ST_CALC1: state_d = ggpf_pkg::ST_CALC2;
      ggpf_pkg::ST_CALC2: state_d = ggpf_pkg::ST_PT_RD;
      ggpf_pkg::ST_PT_RD: begin
        raddr = pt_addr;
        state_d = ggpf_pkg::ST_PT_UPD;
      end
      ggpf_pkg::ST_PT_UPD: begin
        waddr = pt_addr;
        state_d = ggpf_pkg::ST_DONE;
        if (req_q == ggpf_pkg::REQ_ACCUM) begin
          if (flags.range_ok && flags.on_grid) begin
            we = 1'b1;
            if (!r_valid) begin
              wdata = {1'b1, PB'(0), z_q, COUNT_BITS'(1)};
            end else begin
              wdata = {1'b1, r_pass, (z_q < r_h) ? z_q : r_h,
                       (&r_cnt) ? r_cnt : r_cnt + 1'b1};
            end
          end
        end else begin
          res_keep_d = 1'b1;
          priority if (!flags.range_ok) begin
            res_verd_d = ggpf_pkg::VERD_RANGE;
          end else if (!flags.on_grid || !r_valid) begin
            res_verd_d = ggpf_pkg::VERD_NOCELL;
          end else if (HW'(z_q) > lim_h) begin
            res_verd_d = ggpf_pkg::VERD_ABOVE;
          end else begin
            res_keep_d = 1'b0;
            res_verd_d = ggpf_pkg::VERD_GROUND;
          end
        end
      end
      ggpf_pkg::ST_THIN_RD: state_d = ggpf_pkg::ST_THIN_WR;
      ggpf_pkg::ST_THIN_WR: begin
        // Drop thin cells and mark every survivor as accumulated.
        we = 1'b1;
        wdata = {r_valid && (CW'(r_cnt) >= CW'(minpts_q)), PB'(0),
                 rdata[H_LSB +: COORD_BITS], r_cnt};
        cell_d = cell_q + 1'b1;
        if (last_cell) begin
          pass_d = PB'(1);
          state_d = (steps_q == '0) ? ggpf_pkg::ST_DONE : ggpf_pkg::ST_DIL_RD;
        end else begin
          state_d = ggpf_pkg::ST_THIN_RD;
        end
      end
      ggpf_pkg::ST_DIL_RD: state_d = ggpf_pkg::ST_DIL_CHK;
      ggpf_pkg::ST_DIL_CHK: begin
        dir_d = '0;
        found_d = 1'b0;
        if (r_valid) begin
          state_d = ggpf_pkg::ST_DIL_WR;
        end else begin
          state_d = ggpf_pkg::ST_DIL_NRD;
        end
      end
      ggpf_pkg::ST_DIL_NRD: begin
        raddr = nb_addr;
        if (nb_ok) begin
          state_d = ggpf_pkg::ST_DIL_NCHK;
        end else if (dir_q == 2'd3) begin
          state_d = ggpf_pkg::ST_DIL_WR;
        end else begin
          dir_d = dir_q + 1'b1;
        end
      end
      ggpf_pkg::ST_DIL_NCHK: begin
        // Sources are cells that were valid before this pass began.
        if (r_valid && (r_pass < pass_q)) begin
          found_d = 1'b1;
          if (!found_q || (r_h < best_q)) begin
            best_d = r_h;
          end
        end
        if (dir_q == 2'd3) begin
          state_d = ggpf_pkg::ST_DIL_WR;
        end else begin
          dir_d = dir_q + 1'b1;
          state_d = ggpf_pkg::ST_DIL_NRD;
        end
      end
      ggpf_pkg::ST_DIL_WR: begin
        we = found_q;
        wdata = {1'b1, pass_q, best_q, COUNT_BITS'(0)};
        found_d = 1'b0;
        cell_d = cell_q + 1'b1;
        state_d = ggpf_pkg::ST_DIL_RD;
        if (last_cell) begin
          pass_d = pass_q + 1'b1;
          if (pass_q == steps_q) begin
            state_d = ggpf_pkg::ST_DONE;
          end
        end
      end
      ggpf_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_keep_d = res_keep_q;
          out_verd_d = res_verd_q;
          state_d = ggpf_pkg::ST_IDLE;
        end
      end
      default: state_d = ggpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ggpf_pkg::ST_INIT;
      cell_q <= '0;
      pass_q <= '0;
      dir_q <= '0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cell_q <= cell_d;
      pass_q <= pass_d;
      dir_q <= dir_d;
      found_q <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    res_keep_q <= res_keep_d;
    res_verd_q <= res_verd_d;
    out_keep_q <= out_keep_d;
    out_verd_q <= out_verd_d;
    if (accept) begin
      req_q <= ggpf_pkg::req_e'(s_axis_tuser_i);
      x_q <= s_axis_tdata_i[COORD_BITS-1:0];
      y_q <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      z_q <= s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o = {4'b0000, out_verd_q, out_keep_q};

endmodule
`default_nettype wire

>>> design/ggpf_grid_mem.sv
`default_nettype none
module ggpf_grid_mem #(
  parameter int AW = 16,
  parameter int DW = 41
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> design/ggpf_point_calc.sv
`default_nettype none
module ggpf_point_calc #(
  parameter int GRID_SIDE_BITS = ggpf_pkg::GRID_SIDE_BITS_DEF,
  parameter int COORD_BITS     = ggpf_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic signed [COORD_BITS-1:0]         x_i,
  input  wire logic signed [COORD_BITS-1:0]         y_i,
  input  wire logic signed [COORD_BITS-1:0]         z_i,
  input  wire logic [ggpf_pkg::RANGE_W-1:0]         max_range_sq_i,
  input  wire logic [ggpf_pkg::RECIP_W-1:0]         cell_recip_i,
  output ggpf_pkg::pt_flags_t                       flags_o,
  output logic [2*GRID_SIDE_BITS-1:0]               addr_o
);

  localparam int SQ_W = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > ggpf_pkg::RANGE_W) ? SUM_W : ggpf_pkg::RANGE_W;
  localparam int G_W = COORD_BITS + 1;
  localparam int P_W = G_W + ggpf_pkg::RECIP_W + 1;

  logic signed [SQ_W-1:0] sqx_q, sqy_q, sqz_q;
  logic signed [P_W-1:0]  pgx_q, pgy_q;
  logic signed [G_W-1:0]  gx, gy;
  logic signed [ggpf_pkg::RECIP_W:0] recip_s;
  logic [CMP_W-1:0] r2, lim;
  logic signed [P_W-1:0] ix, iy;
  logic ix_ok, iy_ok;

  assign gx = G_W'(y_i);
  assign gy = -G_W'(x_i);
  assign recip_s = $signed({1'b0, cell_recip_i});

  // First stage: the three squares and the two scaled ground coordinates.
  always_ff @(posedge clk_i) begin
    sqx_q <= x_i * x_i;
    sqy_q <= y_i * y_i;
    sqz_q <= z_i * z_i;
    pgx_q <= P_W'(gx) * P_W'(recip_s);
    pgy_q <= P_W'(gy) * P_W'(recip_s);
  end

  assign r2 = CMP_W'($unsigned(sqx_q)) + CMP_W'($unsigned(sqy_q))
            + CMP_W'($unsigned(sqz_q));
  assign lim = CMP_W'(max_range_sq_i);
  assign ix = pgx_q >>> ggpf_pkg::RECIP_FRAC;
  assign iy = pgy_q >>> ggpf_pkg::RECIP_FRAC;
  // The index lies in the grid when all bits above the grid span match its sign.
  assign ix_ok = (&ix[P_W-1:GRID_SIDE_BITS-1]) || !(|ix[P_W-1:GRID_SIDE_BITS-1]);
  assign iy_ok = (&iy[P_W-1:GRID_SIDE_BITS-1]) || !(|iy[P_W-1:GRID_SIDE_BITS-1]);

  always_ff @(posedge clk_i) begin
    flags_o.range_ok <= (r2 <= lim);
    flags_o.on_grid  <= ix_ok && iy_ok;
    addr_o <= {~iy[GRID_SIDE_BITS-1], iy[GRID_SIDE_BITS-2:0],
               ~ix[GRID_SIDE_BITS-1], ix[GRID_SIDE_BITS-2:0]};
  end

endmodule
`default_nettype wire
